[hdl/odib_pkg.sv]
`timescale 1ns / 1ps

package odib_pkg;

	localparam int ID_W    = 48;
	localparam int STAMP_W = 48;

	// command codes
	localparam logic [1:0] MODE_INSERT = 2'd0;
	localparam logic [1:0] MODE_CLEAR  = 2'd1;
	localparam logic [1:0] MODE_READ   = 2'd2;

	// status codes
	localparam logic [2:0] ST_BACK      = 3'd0;
	localparam logic [2:0] ST_FRONT     = 3'd1;
	localparam logic [2:0] ST_MIDDLE    = 3'd2;
	localparam logic [2:0] ST_DUPLICATE = 3'd3;
	localparam logic [2:0] ST_RANGE     = 3'd4;
	localparam logic [2:0] ST_FULL      = 3'd5;
	localparam logic [2:0] ST_DONE      = 3'd6;
	localparam logic [2:0] ST_BAD_INDEX = 3'd7;

	typedef struct packed {
		logic [ID_W-1:0]    id;
		logic [STAMP_W-1:0] stamp;
	} entry_t;

	typedef struct packed {
		logic [1:0]         mode;
		logic [ID_W-1:0]    item_id;
		logic [STAMP_W-1:0] item_stamp;
		logic [5:0]         read_index;
	} in_t;

	typedef struct packed {
		logic [2:0]         status;
		logic [6:0]         entry_count;
		logic [ID_W-1:0]    lowest_id;
		logic [ID_W-1:0]    highest_id;
		logic [STAMP_W-1:0] lowest_stamp;
		logic [STAMP_W-1:0] highest_stamp;
		logic [ID_W-1:0]    read_id;
		logic [STAMP_W-1:0] read_stamp;
	} out_t;

endpackage

[hdl/odib_store.sv]
`timescale 1ns / 1ps

module odib_store #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic            clk,
	input  logic            we,
	input  logic [AW-1:0]   waddr,
	input  odib_pkg::entry_t wdata,
	input  logic [AW-1:0]   raddr,
	output odib_pkg::entry_t rdata
);

	odib_pkg::entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

[hdl/odib_seq.sv]
`timescale 1ns / 1ps

module odib_seq #(
	parameter int BUFFER_DEPTH = 64
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  odib_pkg::in_t  item,
	input  logic           cons_mode,
	output logic           busy,
	output logic           done,
	input  logic           res_take,
	output odib_pkg::out_t res
);

	localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
	localparam int CW = $clog2(BUFFER_DEPTH + 1);
	localparam int IW = (CW > 6) ? CW : 6;
	localparam int EW = (CW > 7) ? CW : 7;
	localparam int IDW = odib_pkg::ID_W;

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_DECIDE = 7'b0000010,
		S_SCAN   = 7'b0000100,
		S_SHIFT  = 7'b0001000,
		S_PLACE  = 7'b0010000,
		S_RDWAIT = 7'b0100000,
		S_FINISH = 7'b1000000
	} state_t;

	state_t state_q;
	odib_pkg::in_t item_q;
	logic [CW-1:0] fill_q;
	logic [IDW-1:0] first_id_q, last_id_q;
	logic [odib_pkg::STAMP_W-1:0] first_stamp_q, last_stamp_q;
	logic [2:0] status_q;
	odib_pkg::entry_t rd_q;
	logic [AW-1:0] ptr_q, pos_q;

	// memory port
	logic we;
	logic [AW-1:0] waddr, raddr;
	odib_pkg::entry_t wdata, rdata, new_entry;

	odib_store #(.DEPTH(BUFFER_DEPTH), .AW(AW)) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	// decision terms
	logic [CW-1:0] fill_m1;
	logic [IW-1:0] idx_w, fill_iw;
	logic [EW-1:0] cnt_w;
	logic [IDW:0] id_x, first_x, last_x;
	logic is_full, is_empty, go_front, go_back, in_range, idx_ok;
	logic scan_eq, scan_gt;
	logic [AW-1:0] ptr_m1;

	assign new_entry = '{id: item_q.item_id, stamp: item_q.item_stamp};
	assign fill_m1   = fill_q - CW'(1);
	assign idx_w     = IW'(item_q.read_index);
	assign fill_iw   = IW'(fill_q);
	assign idx_ok    = idx_w < fill_iw;
	assign cnt_w     = EW'(fill_q);
	assign is_full   = fill_q == CW'(BUFFER_DEPTH);
	assign is_empty  = fill_q == '0;
	assign id_x      = {1'b0, item_q.item_id};
	assign first_x   = {1'b0, first_id_q};
	assign last_x    = {1'b0, last_id_q};
	// 49-bit sums: no wrap at the id limits
	assign go_front  = cons_mode ? (first_x == id_x + (IDW+1)'(1)) : (first_x > id_x);
	assign go_back   = cons_mode ? (last_x + (IDW+1)'(1) == id_x) : (last_x < id_x);
	assign in_range  = (id_x <= last_x) && (id_x >= first_x);
	assign scan_eq   = rdata.id == item_q.item_id;
	assign scan_gt   = rdata.id > item_q.item_id;
	assign ptr_m1    = ptr_q - AW'(1);

	assign busy = state_q != S_IDLE;
	assign done = state_q == S_FINISH;

	always_comb begin
		res.status        = status_q;
		res.entry_count   = cnt_w[6:0];
		res.lowest_id     = first_id_q;
		res.highest_id    = last_id_q;
		res.lowest_stamp  = first_stamp_q;
		res.highest_stamp = last_stamp_q;
		res.read_id       = rd_q.id;
		res.read_stamp    = rd_q.stamp;
	end

	always_comb begin
		we    = 1'b0;
		waddr = '0;
		wdata = new_entry;
		raddr = '0;
		case (state_q)
			S_DECIDE: begin
				case (item_q.mode)
					odib_pkg::MODE_INSERT: begin
						if (!is_full) begin
							if (is_empty) begin
								we = 1'b1;
							end else if (go_front) begin
								raddr = fill_m1[AW-1:0];
							end else if (go_back) begin
								we    = 1'b1;
								waddr = fill_q[AW-1:0];
							end
						end
					end
					odib_pkg::MODE_READ: begin
						raddr = idx_w[AW-1:0];
					end
					default: ;
				endcase
			end
			S_SCAN: begin
				if (scan_gt) begin
					raddr = fill_m1[AW-1:0];
				end else begin
					raddr = ptr_q + AW'(1);
				end
			end
			S_SHIFT: begin
				// rdata holds the entry just below the write slot
				we    = 1'b1;
				waddr = ptr_q;
				wdata = rdata;
				raddr = ptr_q - AW'(2);
			end
			S_PLACE: begin
				we    = 1'b1;
				waddr = pos_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (start) begin
					item_q <= item;
				end
			end
			S_DECIDE: begin
				rd_q   <= '0;
				ptr_q  <= fill_q[AW-1:0];
				pos_q  <= '0;
				if (item_q.mode == odib_pkg::MODE_INSERT && in_range && !cons_mode) begin
					ptr_q <= '0;
				end
			end
			S_SCAN: begin
				if (scan_gt) begin
					pos_q <= ptr_q;
					ptr_q <= fill_q[AW-1:0];
				end else begin
					ptr_q <= ptr_q + AW'(1);
				end
			end
			S_SHIFT: begin
				ptr_q <= ptr_m1;
			end
			S_RDWAIT: begin
				rd_q <= rdata;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			fill_q        <= '0;
			first_id_q    <= '0;
			last_id_q     <= '0;
			first_stamp_q <= '0;
			last_stamp_q  <= '0;
			status_q      <= odib_pkg::ST_DONE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					state_q <= S_FINISH;
					case (item_q.mode)
						odib_pkg::MODE_INSERT: begin
							if (is_full) begin
								status_q <= odib_pkg::ST_FULL;
							end else if (is_empty) begin
								status_q      <= odib_pkg::ST_BACK;
								fill_q        <= fill_q + CW'(1);
								first_id_q    <= item_q.item_id;
								last_id_q     <= item_q.item_id;
								first_stamp_q <= item_q.item_stamp;
								last_stamp_q  <= item_q.item_stamp;
							end else if (go_front) begin
								status_q      <= odib_pkg::ST_FRONT;
								first_id_q    <= item_q.item_id;
								first_stamp_q <= item_q.item_stamp;
								state_q       <= S_SHIFT;
							end else if (go_back) begin
								status_q     <= odib_pkg::ST_BACK;
								fill_q       <= fill_q + CW'(1);
								last_id_q    <= item_q.item_id;
								last_stamp_q <= item_q.item_stamp;
							end else if (in_range) begin
								status_q <= odib_pkg::ST_DUPLICATE;
								if (!cons_mode) begin
									state_q <= S_SCAN;
								end
							end else begin
								status_q <= odib_pkg::ST_RANGE;
							end
						end
						odib_pkg::MODE_CLEAR: begin
							status_q      <= odib_pkg::ST_DONE;
							fill_q        <= '0;
							first_id_q    <= '0;
							last_id_q     <= '0;
							first_stamp_q <= '0;
							last_stamp_q  <= '0;
						end
						odib_pkg::MODE_READ: begin
							if (idx_ok) begin
								status_q <= odib_pkg::ST_DONE;
								state_q  <= S_RDWAIT;
							end else begin
								status_q <= odib_pkg::ST_BAD_INDEX;
							end
						end
						default: begin
							status_q <= odib_pkg::ST_BAD_INDEX;
						end
					endcase
				end
				S_SCAN: begin
					// an entry at or above the id always exists: the last mark is not below the id
					if (scan_eq) begin
						status_q <= odib_pkg::ST_DUPLICATE;
						state_q  <= S_FINISH;
					end else if (scan_gt) begin
						status_q <= odib_pkg::ST_MIDDLE;
						state_q  <= S_SHIFT;
					end
				end
				S_SHIFT: begin
					if (ptr_m1 == pos_q) begin
						state_q <= S_PLACE;
					end
				end
				S_PLACE: begin
					fill_q  <= fill_q + CW'(1);
					state_q <= S_FINISH;
				end
				S_RDWAIT: begin
					state_q <= S_FINISH;
				end
				S_FINISH: begin
					if (res_take) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

[hdl/ordered_dedup_insert_buffer_top.sv]
// Clear, back insert and immediate rejects are settled in the decide state and a read adds a
// read-wait state; a front insert shifts every entry up one slot, then places the item, and a
// middle insert scans from slot 0 for a larger entry, then shifts the entries above it and
// places the item; the same scan finds a duplicate. One item in work at a time, taken once
// the sequencer is back to idle. arst_n clears the count, the end marks, the mode register
// and all handshake state; the entry store is not cleared and needs no pass.
`timescale 1ns / 1ps

module ordered_dedup_insert_buffer_top #(
	parameter int BUFFER_DEPTH = 64
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_we,
	input  logic           cfg_wdata,
	input  logic           item_valid,
	output logic           item_stall,
	input  odib_pkg::in_t  item,
	output logic           result_valid,
	input  logic           result_stall,
	output odib_pkg::out_t result
);

	logic cons_q;
	logic seq_busy, seq_done, res_take;
	odib_pkg::out_t seq_res;
	odib_pkg::out_t result_q;
	logic result_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cons_q <= 1'b0;
		end else if (cfg_we) begin
			cons_q <= cfg_wdata;
		end
	end

	assign item_stall = seq_busy;

	// output register frees the sequencer while a result waits
	assign res_take = seq_done && (!result_valid_q || !result_stall);

	odib_seq #(.BUFFER_DEPTH(BUFFER_DEPTH)) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (item_valid && !seq_busy),
		.item      (item),
		.cons_mode (cons_q),
		.busy      (seq_busy),
		.done      (seq_done),
		.res_take  (res_take),
		.res       (seq_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (res_take) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			result_q <= seq_res;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule
